>>> src/bwb_pkg.sv
// Shared types and constants for the Bayer white-balance demosaic block.
// Used by the channel interfaces, the submodules and the top level.
`default_nettype none
package bwb_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned PixW       = 8;
  localparam int unsigned GainW      = 8;
  localparam int unsigned DimW       = 13;
  localparam int unsigned PosW       = 12;
  localparam int unsigned AddrW      = $clog2(MaxWidth);
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned GainFrac   = 6;

  localparam logic [GainW-1:0] GainRedRst   = 8'd96;
  localparam logic [GainW-1:0] GainGreenRst = 8'd64;
  localparam logic [GainW-1:0] GainBlueRst  = 8'd96;
  localparam logic [DimW-1:0]  WidthRst     = 13'd1920;
  localparam logic [DimW-1:0]  HeightRst    = 13'd1080;

  typedef enum logic [CfgIdxW-1:0] {
    RegGainRed   = 3'd0,
    RegGainGreen = 3'd1,
    RegGainBlue  = 3'd2,
    RegWidth     = 3'd3,
    RegHeight    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0] gain_red;
    logic [GainW-1:0] gain_green;
    logic [GainW-1:0] gain_blue;
    logic [DimW-1:0]  frame_width;
    logic [DimW-1:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic            x_odd;
    logic            y_odd;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } stage_t;

  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] pix;
  } column_t;

endpackage
`default_nettype wire

>>> src/bwb_pix_if.sv
// Raw pixel channel: valid/ready handshake carrying one Bayer sample per word.
// Depends on bwb_pkg.
`default_nettype none
interface bwb_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bwb_pkg::PixW-1:0] raw_pixel;

  modport source (output valid, output raw_pixel, input ready);
  modport sink (input valid, input raw_pixel, output ready);
endinterface
`default_nettype wire

>>> src/bwb_rgb_if.sv
// RGB result channel: valid/ready handshake carrying one demosaiced pixel per word.
// Depends on bwb_pkg.
`default_nettype none
interface bwb_rgb_if;
  logic                     valid;
  logic                     ready;
  logic [bwb_pkg::PixW-1:0] red;
  logic [bwb_pkg::PixW-1:0] green;
  logic [bwb_pkg::PixW-1:0] blue;
  logic [bwb_pkg::PosW-1:0] pixel_x;
  logic [bwb_pkg::PosW-1:0] pixel_y;
  logic                     frame_last;

  modport source (output valid, output red, output green, output blue,
                  output pixel_x, output pixel_y, output frame_last, input ready);
  modport sink (input valid, input red, input green, input blue,
                input pixel_x, input pixel_y, input frame_last, output ready);
endinterface
`default_nettype wire

>>> src/bwb_cfg.sv
// Configuration register file: gains and frame geometry, written by index.
// Depends on bwb_pkg.
`default_nettype none
module bwb_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bwb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bwb_pkg::CfgDataW-1:0] cfg_data_i,
  output bwb_pkg::cfg_t                     cfg_o
);

  bwb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bwb_pkg::RegGainRed:   cfg_d.gain_red     = cfg_data_i[bwb_pkg::GainW-1:0];
        bwb_pkg::RegGainGreen: cfg_d.gain_green   = cfg_data_i[bwb_pkg::GainW-1:0];
        bwb_pkg::RegGainBlue:  cfg_d.gain_blue    = cfg_data_i[bwb_pkg::GainW-1:0];
        bwb_pkg::RegWidth:     cfg_d.frame_width  = cfg_data_i[bwb_pkg::DimW-1:0];
        bwb_pkg::RegHeight:    cfg_d.frame_height = cfg_data_i[bwb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_red     <= bwb_pkg::GainRedRst;
      cfg_q.gain_green   <= bwb_pkg::GainGreenRst;
      cfg_q.gain_blue    <= bwb_pkg::GainBlueRst;
      cfg_q.frame_width  <= bwb_pkg::WidthRst;
      cfg_q.frame_height <= bwb_pkg::HeightRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> src/bwb_linebuf.sv
// Two-row line buffer as one memory: each word holds rows r-2 and r-1 of a column.
// One write and one registered read per cycle. Depends on bwb_pkg.
`default_nettype none
module bwb_linebuf (
  input  wire logic                        clk_i,
  input  wire logic                        rd_en_i,
  input  wire logic [bwb_pkg::AddrW-1:0]   rd_addr_i,
  output logic      [2*bwb_pkg::PixW-1:0]  rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [bwb_pkg::AddrW-1:0]   wr_addr_i,
  input  wire logic [2*bwb_pkg::PixW-1:0]  wr_data_i
);

  logic [2*bwb_pkg::PixW-1:0] mem_q [bwb_pkg::MaxWidth];
  logic [2*bwb_pkg::PixW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

>>> src/bwb_window.sv
// 3x3 neighborhood window, nearest-neighbor color pick and result register.
// Depends on bwb_pkg and bwb_rgb_if.
`default_nettype none
module bwb_window (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire bwb_pkg::stage_t  stage_i,
  input  wire bwb_pkg::column_t col_i,
  output logic                  free_o,
  bwb_rgb_if.source             rgb_o
);

  // wa: column c-1 of the previous step, wb: column c (rows top, mid, bottom)
  logic [bwb_pkg::PixW-1:0] wa_q [3];
  logic [bwb_pkg::PixW-1:0] wb_q [3];

  logic                     valid_q, valid_d;
  logic [bwb_pkg::PixW-1:0] red_q, green_q, blue_q;
  logic [bwb_pkg::PixW-1:0] red_d, green_d, blue_d;
  logic [bwb_pkg::PosW-1:0] x_q, y_q;
  logic                     last_q;

  assign free_o = !valid_q || rgb_o.ready;

  always_comb begin
    case ({stage_i.y_odd, stage_i.x_odd})
      2'b00: begin
        red_d = wb_q[2]; green_d = wb_q[1]; blue_d = wa_q[1];
      end
      2'b01: begin
        red_d = col_i.pix; green_d = wa_q[1]; blue_d = wb_q[1];
      end
      2'b10: begin
        red_d = wb_q[1]; green_d = wb_q[0]; blue_d = col_i.top;
      end
      default: begin
        red_d = wa_q[1]; green_d = wb_q[1]; blue_d = wb_q[0];
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (adv_i) begin
      valid_d = stage_i.emit;
    end else if (rgb_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        wa_q[k] <= '0;
        wb_q[k] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      if (adv_i) begin
        for (int k = 0; k < 3; k++) begin
          wa_q[k] <= wb_q[k];
        end
        wb_q[0] <= col_i.top;
        wb_q[1] <= col_i.mid;
        wb_q[2] <= col_i.pix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && stage_i.emit) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      x_q     <= stage_i.x;
      y_q     <= stage_i.y;
      last_q  <= stage_i.last;
    end
  end

  assign rgb_o.valid      = valid_q;
  assign rgb_o.red        = red_q;
  assign rgb_o.green      = green_q;
  assign rgb_o.blue       = blue_q;
  assign rgb_o.pixel_x    = x_q;
  assign rgb_o.pixel_y    = y_q;
  assign rgb_o.frame_last = last_q;

endmodule
`default_nettype wire

>>> src/bayer_white_balance_demosaic.sv
// GBRG white balance and nearest-neighbor demosaic, top level.
// An accepted raw word passes the stage-1 register and then the window result register; one word per
// cycle sustained while rgb_o.ready holds, with the line buffer read registered at accept.
// Reset clears position counters, window, pipeline valids and restores default registers;
// line-buffer contents are not reset. Depends on bwb_pkg, interfaces and submodules.
`default_nettype none
module bayer_white_balance_demosaic (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bwb_pix_if.sink                           pix_i,
  bwb_rgb_if.source                         rgb_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bwb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bwb_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned DimW = bwb_pkg::DimW;
  localparam int unsigned PosW = bwb_pkg::PosW;
  localparam int unsigned PixW = bwb_pkg::PixW;
  localparam int unsigned ProdW = PixW + bwb_pkg::GainW - bwb_pkg::GainFrac;

  bwb_pkg::cfg_t    cfg;
  bwb_pkg::stage_t  stage_q, stage_d;
  bwb_pkg::column_t col;

  logic [DimW-1:0]  w_lim, h_lim;
  logic [PosW-1:0]  row_q, row_d, col_q, col_d;
  logic [DimW-1:0]  row_p1, col_p1, row_p2, col_p2;
  logic             s1_valid_q;
  logic [PixW-1:0]  raw_q;
  logic [bwb_pkg::GainW-1:0] gain_q, gain_d;
  logic [PosW-1:0]  wcol_q;
  logic [2*PixW-1:0] rd_data;
  logic [PixW+bwb_pkg::GainW-1:0] prod;
  logic [ProdW-1:0] scaled;
  logic [PixW-1:0]  pix;
  logic             accept, adv, free;

  bwb_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  always_comb begin
    if (cfg.frame_width == '0) begin
      w_lim = DimW'(1);
    end else if (cfg.frame_width > DimW'(bwb_pkg::MaxWidth)) begin
      w_lim = DimW'(bwb_pkg::MaxWidth);
    end else begin
      w_lim = cfg.frame_width;
    end
    if (cfg.frame_height == '0) begin
      h_lim = DimW'(1);
    end else if (cfg.frame_height > DimW'(bwb_pkg::MaxHeight)) begin
      h_lim = DimW'(bwb_pkg::MaxHeight);
    end else begin
      h_lim = cfg.frame_height;
    end
  end

  assign adv         = s1_valid_q && free;
  assign pix_i.ready = !s1_valid_q || free;
  assign accept      = pix_i.valid && pix_i.ready;

  assign row_p1 = {1'b0, row_q} + DimW'(1);
  assign col_p1 = {1'b0, col_q} + DimW'(1);
  assign row_p2 = {1'b0, row_q} + DimW'(2);
  assign col_p2 = {1'b0, col_q} + DimW'(2);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_p1 >= w_lim) begin
      col_d = '0;
      row_d = (row_p1 >= h_lim) ? '0 : row_p1[PosW-1:0];
    end else begin
      col_d = col_p1[PosW-1:0];
    end
  end

  always_comb begin
    if (row_q[0] == col_q[0]) begin
      gain_d = cfg.gain_green;
    end else if (!row_q[0]) begin
      gain_d = cfg.gain_blue;
    end else begin
      gain_d = cfg.gain_red;
    end
    stage_d.emit  = (row_q >= PosW'(2)) && (col_q >= PosW'(2))
                    && (row_p2 <= h_lim) && (col_p2 <= w_lim);
    stage_d.last  = (row_p2 == h_lim) && (col_p2 == w_lim);
    stage_d.x     = col_q - PosW'(1);
    stage_d.y     = row_q - PosW'(1);
    stage_d.x_odd = !col_q[0];
    stage_d.y_odd = !row_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q   <= pix_i.raw_pixel;
      gain_q  <= gain_d;
      wcol_q  <= col_q;
      stage_q <= stage_d;
    end
  end

  bwb_linebuf u_linebuf (
    .clk_i,
    .rd_en_i   (accept),
    .rd_addr_i (col_q[bwb_pkg::AddrW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (adv),
    .wr_addr_i (wcol_q[bwb_pkg::AddrW-1:0]),
    .wr_data_i ({rd_data[PixW-1:0], pix})
  );

  assign prod   = (PixW + bwb_pkg::GainW)'(raw_q) * (PixW + bwb_pkg::GainW)'(gain_q);
  assign scaled = prod[PixW+bwb_pkg::GainW-1:bwb_pkg::GainFrac];
  assign pix    = (scaled > ProdW'(255)) ? 8'hFF : scaled[PixW-1:0];

  assign col.top = rd_data[2*PixW-1:PixW];
  assign col.mid = rd_data[PixW-1:0];
  assign col.pix = pix;

  bwb_window u_window (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .stage_i (stage_q),
    .col_i   (col),
    .free_o  (free),
    .rgb_o
  );

endmodule
`default_nettype wire
